// ===== rtl/core/ps2_set1_scancode_to_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// PS/2 set 1 decoder assertion macros
// Checks used by the top-level decoder, one macro use per assertion.
// ----------------------------------------------------------------------------
`ifndef PS2_SET1_SCANCODE_TO_ASCII_ASSERT_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_ASSERT_SVH

// When the condition holds at an edge, the consequence holds at the same edge.
`define PS2S_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> (conseq)) else $error(msg);

// When the condition holds at an edge, the consequence holds at the next edge.
`define PS2S_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (conseq)) else $error(msg);

`endif

// ===== rtl/core/ps2s_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 set 1 decoder package
// Transaction types, scan code constants and the key translation tables.
// ----------------------------------------------------------------------------
package ps2s_pkg;

	typedef struct packed {
		logic [7:0] scan_byte;
	} scan_item_t;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] key_code;
		logic       key_pressed;
		logic [6:0] ascii_char;
		logic       last_of_run;
	} event_item_t;

	// Decoder outcome for one byte, handed to the flag registers and output buffer.
	typedef struct packed {
		logic       swallow;
		logic       has_char;
		logic [6:0] ascii_char;
		logic       shift_nxt;
		logic       caps_nxt;
		logic       ext_nxt;
	} dec_t;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

	localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
	localparam logic [6:0] CASE_OFFSET  = 7'h20;

	// Unshifted character for a make code; zero means the key has no character.
	function automatic logic [6:0] key_lookup(input logic [6:0] code);
		logic [6:0] c;
		unique case (code)
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h47: c = 7'h37;
			7'h48: c = 7'h38;
			7'h49: c = 7'h39;
			7'h4A: c = 7'h2D;
			7'h4B: c = 7'h34;
			7'h4C: c = 7'h35;
			7'h4D: c = 7'h36;
			7'h4E: c = 7'h2B;
			7'h4F: c = 7'h31;
			7'h50: c = 7'h32;
			7'h51: c = 7'h33;
			7'h52: c = 7'h30;
			7'h53: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Shifted form of a character; characters without one pass unchanged.
	function automatic logic [6:0] shift_map(input logic [6:0] c);
		logic [6:0] r;
		unique case (c)
			7'h5B: r = 7'h7B;
			7'h5C: r = 7'h7C;
			7'h5D: r = 7'h7D;
			7'h60: r = 7'h7E;
			7'h27: r = 7'h22;
			7'h28: r = 7'h28;
			7'h29: r = 7'h29;
			7'h2A: r = 7'h2A;
			7'h2B: r = 7'h2B;
			7'h2C: r = 7'h3C;
			7'h2D: r = 7'h5F;
			7'h2E: r = 7'h3E;
			7'h2F: r = 7'h3F;
			7'h30: r = 7'h29;
			7'h31: r = 7'h21;
			7'h32: r = 7'h40;
			7'h33: r = 7'h23;
			7'h34: r = 7'h24;
			7'h35: r = 7'h25;
			7'h36: r = 7'h5E;
			7'h37: r = 7'h26;
			7'h38: r = 7'h2A;
			7'h39: r = 7'h28;
			7'h3A: r = 7'h3A;
			7'h3B: r = 7'h3A;
			7'h3C: r = 7'h3C;
			7'h3D: r = 7'h2B;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/ps2s_chan_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 decoder channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ps2s_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ps2s_decode.sv =====
// ----------------------------------------------------------------------------
// PS/2 set 1 byte decoder
// Translates one scan byte against the modifier flags and gives next flags.
// ----------------------------------------------------------------------------
module ps2s_decode (
	input  logic [7:0]   scan_byte,
	input  logic         shift_held,
	input  logic         caps_lock_on,
	input  logic         extended_pending,
	output ps2s_pkg::dec_t dec
);
	import ps2s_pkg::*;

	logic [6:0] base_char;
	logic [6:0] shifted_char;
	logic       is_lower;

	assign base_char    = scan_byte[7] ? 7'h00 : key_lookup(scan_byte[6:0]);
	assign shifted_char = shift_held ? shift_map(base_char) : base_char;
	assign is_lower     = (shifted_char >= CHAR_LOWER_A) && (shifted_char <= CHAR_LOWER_Z);

	always_comb begin
		dec            = '0;
		dec.shift_nxt  = shift_held;
		dec.caps_nxt   = caps_lock_on;
		dec.ext_nxt    = 1'b0;
		if (extended_pending) begin
			// The byte after an extended prefix is dropped without any event.
			dec.swallow = 1'b1;
		end else begin
			unique case (scan_byte)
				SC_EXT_PREFIX: dec.ext_nxt = 1'b1;
				SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: dec.shift_nxt = 1'b1;
				SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: dec.shift_nxt = 1'b0;
				SC_CAPS_MAKE: dec.caps_nxt = ~caps_lock_on;
				default: begin
					if ((shift_held ^ caps_lock_on) && is_lower) begin
						dec.ascii_char = shifted_char - CASE_OFFSET;
					end else begin
						dec.ascii_char = shifted_char;
					end
					dec.has_char = (shifted_char != 7'h00);
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/ps2s_out_buf.sv =====
// ----------------------------------------------------------------------------
// PS/2 decoder result buffer
// Holds the events of one byte and presents them one transaction at a time.
// ----------------------------------------------------------------------------
module ps2s_out_buf (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] load_code,
	input  logic       load_has_char,
	input  logic [6:0] load_char,
	output logic       free,
	ps2s_chan_if.source evt_out
);
	import ps2s_pkg::*;

	logic       vld_q;
	logic       phase_q;
	logic [7:0] code_q;
	logic       has_char_q;
	logic [6:0] char_q;
	logic       last;
	logic       fire;

	// The key event comes first; the character event, if any, closes the run.
	assign last = phase_q | ~has_char_q;
	assign fire = vld_q & evt_out.ready;
	assign free = ~vld_q | (evt_out.ready & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			vld_q   <= 1'b1;
			phase_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				vld_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q     <= load_code;
			has_char_q <= load_has_char;
			char_q     <= load_char;
		end
	end

	always_comb begin
		evt_out.valid               = vld_q;
		evt_out.payload.key_code    = code_q;
		evt_out.payload.last_of_run = last;
		if (phase_q) begin
			evt_out.payload.event_kind  = KIND_CHAR;
			evt_out.payload.key_pressed = 1'b1;
			evt_out.payload.ascii_char  = char_q;
		end else begin
			evt_out.payload.event_kind  = KIND_KEY;
			evt_out.payload.key_pressed = ~code_q[7];
			evt_out.payload.ascii_char  = 7'h00;
		end
	end
endmodule

// ===== rtl/core/ps2_set1_scancode_to_ascii.sv =====
// ----------------------------------------------------------------------------
// PS/2 scan code set 1 to ASCII decoder
// Turns keyboard scan bytes into key events and character events.
// ----------------------------------------------------------------------------
// Usage:
// scan_in takes one raw set 1 scan byte per transaction. evt_out gives, for
// each byte, a key event and, for a make code that has a character, a
// character event after it; last_of_run marks the final event of a byte.
// A byte that follows an extended prefix produces no event.
// An accepted byte is registered in the input register, decoded
// combinationally and, once the result register is free, placed in it;
// its first event is then offered on evt_out.
// Throughput: one byte per cycle while evt_out is ready, for bytes with a
// key event only; a byte with a character event holds the result register
// until both of its events are taken, and the next byte waits meanwhile.
// Reset clears the shift, caps-lock and extended-prefix flags and empties
// both the input register and the result register.
// When evt_out stalls, the result register holds its event and the input
// register takes bytes until one needs the result register; then scan_in.ready drops.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_to_ascii (
	input  logic clk,
	input  logic arst_n,
	ps2s_chan_if.sink   scan_in,
	ps2s_chan_if.source evt_out
);
	import ps2s_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       shift_q;
	logic       caps_q;
	logic       ext_q;
	dec_t       dec;
	logic       free;
	logic       adv;
	logic       load;

	ps2s_decode u_decode (
		.scan_byte        (byte_s1),
		.shift_held       (shift_q),
		.caps_lock_on     (caps_q),
		.extended_pending (ext_q),
		.dec              (dec)
	);

	// A swallowed byte leaves the input register without touching the results.
	assign adv  = vld_s1 & (dec.swallow | free);
	assign load = vld_s1 & ~dec.swallow & free;

	assign scan_in.ready = ~vld_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			ext_q   <= 1'b0;
		end else begin
			if (scan_in.valid && scan_in.ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				shift_q <= dec.shift_nxt;
				caps_q  <= dec.caps_nxt;
				ext_q   <= dec.ext_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.valid && scan_in.ready) begin
			byte_s1 <= scan_in.payload.scan_byte;
		end
	end

	ps2s_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.load_code     (byte_s1),
		.load_has_char (dec.has_char),
		.load_char     (dec.ascii_char),
		.free          (free),
		.evt_out       (evt_out)
	);

`include "ps2_set1_scancode_to_ascii_assert.svh"

	`PS2S_ASSERT_SAME(a_char_closes_run, evt_out.valid && evt_out.payload.event_kind == KIND_CHAR, evt_out.payload.last_of_run && evt_out.payload.key_pressed, "character event must be a pressed key and end its run")
	`PS2S_ASSERT_NEXT(a_char_follows_key, evt_out.valid && evt_out.ready && !evt_out.payload.last_of_run, evt_out.valid && evt_out.payload.event_kind == KIND_CHAR, "a key event without last_of_run must be followed by its character event")
	`PS2S_ASSERT_SAME(a_char_nonzero, evt_out.valid, (evt_out.payload.event_kind == KIND_CHAR) == (evt_out.payload.ascii_char != 7'h00), "ascii_char must be nonzero exactly on character events")
	`PS2S_ASSERT_NEXT(a_ext_swallow, vld_s1 && ext_q, !ext_q || !$past(adv), "extended prefix flag must clear when the following byte is consumed")

endmodule

// ===== tb/tb_ps2_set1_scancode_to_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 set 1 decoder testbench
// Feeds scan bytes through the valid/ready input channel, including directed
// modifier, caps-lock, extended-prefix and break-code sequences followed by
// random typing traffic. It predicts the key and character events from its
// own copy of the shift, caps and prefix flags and checks every output
// transaction in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ps2_set1_scancode_to_ascii;
	import ps2s_pkg::*;

	localparam int RANDOM_BYTES   = 1900;
	localparam int BLOCK_BYTES    = 100;
	localparam int HOLD_CYCLES    = 250;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	ps2s_chan_if #(.payload_t(scan_item_t))  scan_ch ();
	ps2s_chan_if #(.payload_t(event_item_t)) evt_ch ();

	ps2_set1_scancode_to_ascii u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_in (scan_ch),
		.evt_out (evt_ch)
	);

	always #1 clk = ~clk;

	logic [7:0]  scan_backlog[$];
	event_item_t expected_events[$];

	// Predicted keyboard state.
	logic shift_down;
	logic caps_active;
	logic prefix_pending;

	logic src_idle;
	logic snk_idle;
	int   hold_asked;
	int   hold_served;
	int   bytes_taken;
	int   bytes_queued;
	int   key_events;
	int   char_events;
	int   fail_count;

	// Unshifted character of a make code; zero for keys without one.
	function automatic logic [6:0] base_char(input logic [7:0] code);
		logic [7:0] c;
		case (code)
			8'h02: c = "1";
			8'h03: c = "2";
			8'h04: c = "3";
			8'h05: c = "4";
			8'h06: c = "5";
			8'h07: c = "6";
			8'h08: c = "7";
			8'h09: c = "8";
			8'h0A: c = "9";
			8'h0B: c = "0";
			8'h0C: c = "-";
			8'h0D: c = "=";
			8'h0E: c = 8'h08;
			8'h0F: c = 8'h09;
			8'h10: c = "q";
			8'h11: c = "w";
			8'h12: c = "e";
			8'h13: c = "r";
			8'h14: c = "t";
			8'h15: c = "y";
			8'h16: c = "u";
			8'h17: c = "i";
			8'h18: c = "o";
			8'h19: c = "p";
			8'h1A: c = "[";
			8'h1B: c = "]";
			8'h1C: c = 8'h0A;
			8'h1E: c = "a";
			8'h1F: c = "s";
			8'h20: c = "d";
			8'h21: c = "f";
			8'h22: c = "g";
			8'h23: c = "h";
			8'h24: c = "j";
			8'h25: c = "k";
			8'h26: c = "l";
			8'h27: c = ";";
			8'h28: c = "'";
			8'h29: c = 8'h60;
			8'h2B: c = "\\";
			8'h2C: c = "z";
			8'h2D: c = "x";
			8'h2E: c = "c";
			8'h2F: c = "v";
			8'h30: c = "b";
			8'h31: c = "n";
			8'h32: c = "m";
			8'h33: c = ",";
			8'h34: c = ".";
			8'h35: c = "/";
			8'h37: c = "*";
			8'h39: c = " ";
			8'h47: c = "7";
			8'h48: c = "8";
			8'h49: c = "9";
			8'h4A: c = "-";
			8'h4B: c = "4";
			8'h4C: c = "5";
			8'h4D: c = "6";
			8'h4E: c = "+";
			8'h4F: c = "1";
			8'h50: c = "2";
			8'h51: c = "3";
			8'h52: c = "0";
			8'h53: c = ".";
			default: c = 8'h00;
		endcase
		return c[6:0];
	endfunction

	// Shifted form of a character. Backtick (0x60) becomes a tilde.
	function automatic logic [6:0] shifted_char(input logic [6:0] c);
		logic [7:0] x;
		logic [7:0] r;
		x = {1'b0, c};
		case (x)
			"[":     r = "{";
			"\\":    r = "|";
			"]":     r = "}";
			8'h60:   r = "~";
			"'":     r = "\"";
			"(":     r = "(";
			")":     r = ")";
			"*":     r = "*";
			"+":     r = "+";
			",":     r = "<";
			"-":     r = "_";
			".":     r = ">";
			"/":     r = "?";
			"0":     r = ")";
			"1":     r = "!";
			"2":     r = "@";
			"3":     r = "#";
			"4":     r = "$";
			"5":     r = "%";
			"6":     r = "^";
			"7":     r = "&";
			"8":     r = "*";
			"9":     r = "(";
			":":     r = ":";
			";":     r = ":";
			"<":     r = "<";
			"=":     r = "+";
			default: r = x;
		endcase
		return r[6:0];
	endfunction

	task automatic predict_events(input logic [7:0] sc);
		logic [6:0]  c;
		event_item_t ev;
		c = 7'h00;
		if (prefix_pending) begin
			// The byte after an extended prefix is dropped without an event.
			prefix_pending = 1'b0;
			return;
		end
		case (sc)
			SC_EXT_PREFIX: prefix_pending = 1'b1;
			SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: shift_down = 1'b1;
			SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_down = 1'b0;
			SC_CAPS_MAKE: caps_active = ~caps_active;
			default: begin
				c = base_char(sc);
				if (c != 7'h00) begin
					if (shift_down)
						c = shifted_char(c);
					if ((shift_down != caps_active) && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
						c = c - CASE_OFFSET;
				end
			end
		endcase
		ev.event_kind  = KIND_KEY;
		ev.key_code    = sc;
		ev.key_pressed = ~sc[7];
		ev.ascii_char  = 7'h00;
		ev.last_of_run = (c == 7'h00);
		expected_events.push_back(ev);
		if (c != 7'h00) begin
			ev.event_kind  = KIND_CHAR;
			ev.key_pressed = 1'b1;
			ev.ascii_char  = c;
			ev.last_of_run = 1'b1;
			expected_events.push_back(ev);
		end
	endtask

	// Idle length: mostly none, sometimes short, rarely a long stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		scan_backlog.push_back(b);
		bytes_queued++;
	endtask

	// A make code from 0x00 to 0x57 followed by its break code.
	task automatic queue_keystroke();
		logic [7:0] k;
		k = 8'($urandom_range(0, 8'h57));
		queue_byte(k);
		queue_byte(k | 8'h80);
	endtask

	task automatic queue_typing(input int n);
		int target;
		int r;
		target = bytes_queued + n;
		while (bytes_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				queue_keystroke();
			end else if (r < 62) begin
				queue_byte($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
				repeat ($urandom_range(1, 4)) queue_keystroke();
				queue_byte($urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
			end else if (r < 68) begin
				queue_byte(SC_CAPS_MAKE);
				queue_byte(SC_CAPS_MAKE | 8'h80);
			end else if (r < 77) begin
				queue_byte(SC_EXT_PREFIX);
				case ($urandom_range(0, 3))
					0: queue_byte(SC_EXT_PREFIX);
					1: queue_byte(SC_LSHIFT_MAKE);
					2: queue_byte(SC_CAPS_MAKE);
					default: queue_byte(8'($urandom_range(0, 255)));
				endcase
			end else begin
				queue_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Input driver.
	always @(posedge clk or negedge arst_n) begin : scan_driver
		logic offer_next;
		int   send_gap;
		if (!arst_n) begin
			scan_ch.valid   <= 1'b0;
			scan_ch.payload <= '0;
			send_gap = 0;
		end else begin
			offer_next = 1'b1;
			if (scan_ch.valid && scan_ch.ready) begin
				predict_events(scan_ch.payload.scan_byte);
				bytes_taken++;
				send_gap = src_idle ? pick_gap() : 0;
			end else if (scan_ch.valid) begin
				offer_next = 1'b0;
			end
			if (offer_next) begin
				if (send_gap > 0) begin
					send_gap--;
					scan_ch.valid <= 1'b0;
				end else if (scan_backlog.size() > 0) begin
					scan_ch.valid             <= 1'b1;
					scan_ch.payload.scan_byte <= scan_backlog.pop_front();
				end else begin
					scan_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Output monitor and ready generator.
	always @(posedge clk or negedge arst_n) begin : event_monitor
		event_item_t want;
		event_item_t got;
		int          stall_left;
		logic        ready_next;
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (evt_ch.valid && evt_ch.ready) begin
				got = evt_ch.payload;
				if (got.event_kind == KIND_CHAR)
					char_events++;
				else
					key_events++;
				if (expected_events.size() == 0) begin
					$error("event with nothing expected: %p", got);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", int'(want.event_kind), int'(got.event_kind));
					check_field("key_code", int'(want.key_code), int'(got.key_code));
					check_field("key_pressed", int'(want.key_pressed),
						int'(got.key_pressed));
					check_field("ascii_char", int'(want.ascii_char), int'(got.ascii_char));
					check_field("last_of_run", int'(want.last_of_run),
						int'(got.last_of_run));
				end
			end
			if (stall_left == 0 && hold_served != hold_asked) begin
				// Long hold-off so that the decoder backs up into its input.
				hold_served++;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && snk_idle) begin
				stall_left = pick_gap();
			end
			ready_next = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			evt_ch.ready <= ready_next;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (scan_ch.valid && scan_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int block;
		scan_ch.valid   = 1'b0;
		scan_ch.payload = '0;
		evt_ch.ready    = 1'b0;
		arst_n          = 1'b0;
		shift_down      = 1'b0;
		caps_active     = 1'b0;
		prefix_pending  = 1'b0;
		src_idle        = 1'b0;
		snk_idle        = 1'b0;
		hold_asked      = 0;
		hold_served     = 0;
		bytes_taken     = 0;
		bytes_queued    = 0;
		key_events      = 0;
		char_events     = 0;
		fail_count      = 0;
		block           = 0;

		// Directed part: table ends, shift, caps, their combination, the
		// extended prefix (also twice in a row), break codes and codes past
		// the key table.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h02);
		queue_byte(8'h1E);
		queue_byte(8'h1C);
		queue_byte(SC_LSHIFT_MAKE);
		queue_byte(8'h1E);
		queue_byte(8'h02);
		queue_byte(8'h1A);
		queue_byte(8'h28);
		queue_byte(8'h4E);
		queue_byte(SC_LSHIFT_BREAK);
		queue_byte(SC_CAPS_MAKE);
		queue_byte(8'h1E);
		queue_byte(SC_RSHIFT_MAKE);
		queue_byte(8'h1E);
		queue_byte(SC_RSHIFT_BREAK);
		queue_byte(SC_CAPS_MAKE | 8'h80);
		queue_byte(SC_CAPS_MAKE);
		queue_byte(SC_EXT_PREFIX);
		queue_byte(SC_LSHIFT_MAKE);
		queue_byte(8'h1E);
		queue_byte(SC_EXT_PREFIX);
		queue_byte(SC_EXT_PREFIX);
		queue_byte(8'h9E);
		queue_byte(8'h58);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Random typing in blocks; each block picks its own idling, and a
		// few run the source flat out against a long output hold-off.
		while (bytes_queued < RANDOM_BYTES + 26) begin
			while (scan_backlog.size() > 20)
				@(posedge clk);
			block++;
			if (block % 6 == 3) begin
				src_idle   <= 1'b0;
				snk_idle   <= 1'b0;
				hold_asked <= hold_asked + 1;
			end else begin
				src_idle <= ($urandom_range(0, 3) != 0);
				snk_idle <= ($urandom_range(0, 3) != 0);
			end
			queue_typing(BLOCK_BYTES);
		end

		while (scan_backlog.size() > 0 || scan_ch.valid)
			@(posedge clk);
		while (expected_events.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_events.size() > 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			fail_count++;
		end
		$display("Decoded %0d scan bytes into %0d key and %0d character events,",
			bytes_taken, key_events, char_events);
		$display("with %0d long output hold-offs and random idling on both sides.",
			hold_served);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
